// ===== sv/quadrature_speed_and_stall_monitor_macros.svh =====
// Assertion macros used by the speed and stall monitor RTL.
`ifndef QUADRATURE_SPEED_AND_STALL_MONITOR_MACROS_SVH
`define QUADRATURE_SPEED_AND_STALL_MONITOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QSSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define QSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/qssm_pkg.sv =====
// Types and constants of the quadrature speed and stall monitor.
package qssm_pkg;

  // Divider operand widths: |delta| * 60000 * 256 fits 55 bits, ppr * dt fits 48 bits
  localparam int unsigned NUM_W = 55;
  localparam int unsigned DEN_W = 48;

  // 60000 ms/min scaled to Q.8
  localparam logic [23:0] SPEED_K = 24'd15360000;

  // Hardware counter span added or removed on a wrap
  localparam logic [31:0] COUNTER_SPAN = 32'h0001_0000;

  // Register reset values
  localparam logic [15:0] PPR_RST        = 16'd13;
  localparam logic [15:0] WINDOW_RST     = 16'd50;
  localparam logic [15:0] STALL_LIM_RST  = 16'd10;
  localparam logic [15:0] STALL_RPM_RST  = 16'd5;

  typedef enum logic [1:0] {
    REQ_SPEED     = 2'd0,
    REQ_WRAP_UP   = 2'd1,
    REQ_WRAP_DOWN = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_PPR       = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_STALL_LIM = 2'd2,
    REG_STALL_RPM = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_ABS,
    S_MULA,
    S_MULB,
    S_DIV,
    S_SAT,
    S_STALL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/quadrature_speed_and_stall_monitor.sv =====
// Wrap and clear words go straight to S_DONE; a speed word passes S_WIN, then S_ABS,
// S_MULA, S_MULB, the 55-step serial divider and S_SAT if it recomputes the rpm, then
// S_STALL. One word in flight: in_ready_o is high only while idle, so a new word is
// taken once the last has left; a finished word waits in S_DONE for the output register.
// Reset (asynchronous, active low) clears position, speed and stall state and loads
// the register defaults: 13 pulses/rev, 50 ms window, limit 10, stall level 5 rpm.
`include "quadrature_speed_and_stall_monitor_macros.svh"

module quadrature_speed_and_stall_monitor
  import qssm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] raw_count_i,
  input  logic signed [15:0] drive_level_i,
  // Result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] rpm_q8_o,
  output logic        stall_fault_o
);

  // Registers
  logic [15:0] ppr_q, win_q, lim_q, srpm_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  // Sequencer and state
  state_e      state_q, state_d;
  logic [31:0] offset_q, prev_pos_q, prev_time_q, speed_q;
  logic [15:0] slow_cnt_q;
  logic        out_valid_q;
  logic [31:0] out_pos_q, out_rpm_q;
  logic        out_fault_q;

  // Per-word payload
  logic [31:0] pos_q, now_q, dt_q, delta_q;
  logic [NUM_W-1:0] num_q;
  logic        neg_q, drive_on_q, fault_q;

  // Datapath nets
  logic        accept, out_load, recompute;
  logic [31:0] offset_nx;
  logic [15:0] ppr_eff, win_eff;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;
  logic [31:0] sat_val;
  logic [31:0] spd_mag;
  logic        slow;
  logic [15:0] slow_inc;
  logic        fault_d;
  logic [15:0] slow_cnt_d;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q  <= PPR_RST;
      win_q  <= WINDOW_RST;
      lim_q  <= STALL_LIM_RST;
      srpm_q <= STALL_RPM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PPR:       ppr_q  <= pwdata[15:0];
        REG_WINDOW:    win_q  <= pwdata[15:0];
        REG_STALL_LIM: lim_q  <= pwdata[15:0];
        REG_STALL_RPM: srpm_q <= pwdata[15:0];
        default:       ppr_q  <= ppr_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PPR:       prdata = {16'h0000, ppr_q};
      REG_WINDOW:    prdata = {16'h0000, win_q};
      REG_STALL_LIM: prdata = {16'h0000, lim_q};
      REG_STALL_RPM: prdata = {16'h0000, srpm_q};
      default:       prdata = '0;
    endcase
  end

  // Zero pulses per rev and zero window both act as one
  assign ppr_eff = (ppr_q == '0) ? 16'd1 : ppr_q;
  assign win_eff = (win_q == '0) ? 16'd1 : win_q;

  // Handshakes
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign recompute  = (dt_q >= {16'h0000, win_eff});

  // Move the offset by one counter span on a wrap, drop it on a clear
  always_comb begin
    case (req_e'(req_type_i))
      REQ_WRAP_UP:   offset_nx = offset_q + COUNTER_SPAN;
      REQ_WRAP_DOWN: offset_nx = offset_q - COUNTER_SPAN;
      REQ_CLEAR:     offset_nx = '0;
      default:       offset_nx = offset_q;
    endcase
  end

  // Shared multiplier: |delta| * K first, then dt * ppr
  always_comb begin
    if (state_q == S_MULA) begin
      mul_a = delta_q;
      mul_b = SPEED_K;
    end else begin
      mul_a = dt_q;
      mul_b = {8'h00, ppr_eff};
    end
    mul_p = mul_a * mul_b;
  end

  assign div_req.start = (state_q == S_MULB);
  assign div_req.num   = num_q;
  assign div_req.den   = mul_p[DEN_W-1:0];

  qssm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Saturate the quotient and apply the sign
  always_comb begin
    if (!neg_q) begin
      if ((|div_rsp.quot[NUM_W-1:32]) || div_rsp.quot[31]) begin
        sat_val = 32'h7FFF_FFFF;
      end else begin
        sat_val = div_rsp.quot[31:0];
      end
    end else begin
      if ((|div_rsp.quot[NUM_W-1:32]) || (div_rsp.quot[31] && (|div_rsp.quot[30:0]))) begin
        sat_val = 32'h8000_0000;
      end else begin
        sat_val = 32'h0 - div_rsp.quot[31:0];
      end
    end
  end

  // Stall test on the speed magnitude
  always_comb begin
    spd_mag    = speed_q[31] ? (32'h0 - speed_q) : speed_q;
    slow       = drive_on_q && (spd_mag < {8'h00, srpm_q, 8'h00});
    slow_inc   = slow_cnt_q + 16'd1;
    fault_d    = 1'b0;
    slow_cnt_d = '0;
    if (slow) begin
      if (slow_inc >= lim_q) begin
        fault_d = 1'b1;
      end else begin
        slow_cnt_d = slow_inc;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (req_e'(req_type_i) == REQ_SPEED) ? S_WIN : S_DONE;
        end
      end
      S_WIN:   state_d = recompute ? S_ABS : S_STALL;
      S_ABS:   state_d = S_MULA;
      S_MULA:  state_d = S_MULB;
      S_MULB:  state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_SAT;
        end
      end
      S_SAT:   state_d = S_STALL;
      S_STALL: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer, model state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      offset_q    <= '0;
      prev_pos_q  <= '0;
      prev_time_q <= '0;
      speed_q     <= '0;
      slow_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        offset_q <= offset_nx;
      end
      if ((state_q == S_WIN) && recompute) begin
        prev_pos_q  <= pos_q;
        prev_time_q <= now_q;
      end
      if (state_q == S_SAT) begin
        speed_q <= sat_val;
      end
      if (state_q == S_STALL) begin
        slow_cnt_q <= slow_cnt_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q      <= offset_nx + {16'h0000, raw_count_i};
      now_q      <= now_ms_i;
      dt_q       <= now_ms_i - prev_time_q;
      drive_on_q <= (drive_level_i != '0);
      fault_q    <= 1'b0;
    end
    if ((state_q == S_WIN) && recompute) begin
      delta_q <= pos_q - prev_pos_q;
    end
    if (state_q == S_ABS) begin
      neg_q   <= delta_q[31];
      delta_q <= delta_q[31] ? (32'h0 - delta_q) : delta_q;
    end
    if (state_q == S_MULA) begin
      num_q <= mul_p[NUM_W-1:0];
    end
    if (state_q == S_STALL) begin
      fault_q <= fault_d;
    end
    if (out_load) begin
      out_pos_q   <= pos_q;
      out_rpm_q   <= speed_q;
      out_fault_q <= fault_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign position_o    = out_pos_q;
  assign rpm_q8_o      = out_rpm_q;
  assign stall_fault_o = out_fault_q;

  // Checks
  `QSSM_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_q == S_DIV,
                   "divider finished outside the divide step")
  `QSSM_ASSERT_NOW(a_idle_div_free, state_q == S_IDLE, !div_rsp.busy,
                   "divider busy while sequencer idle")
  `QSSM_ASSERT_NEXT(a_fault_clears, (state_q == S_STALL) && fault_d,
                    (slow_cnt_q == '0) && fault_q, "stall counter not cleared on fault")

endmodule

// ===== sv/qssm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module qssm_div
  import qssm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(NUM_W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DEN_W:0]  rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             fits;

  // Shift in the next numerator bit and trial-subtract the divisor
  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    fits   = !diff[DEN_W+1];
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W:0] : rem_sh;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
